// ----- rtl/core/csort_pkg.sv -----
// Shared types and constants for the counting sort engine.
`default_nettype none

package csort_pkg;

   localparam int unsigned VALUE_W    = 12;
   localparam int unsigned TOTAL_BITS = 28;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DRAIN  = 1'b1
   } csort_op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN
   } csort_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;    // write zero to the next bin of the clearing pass
      logic accept;        // capture the request and issue its first bin read
      logic finish_insert; // bin count is back: decide and update
      logic scan;          // bin count is back: test it, step on if empty
      logic load_rsp;      // load the result register
   } csort_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic bin_nonzero;
      logic store_empty;
   } csort_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/csort_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csort_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/csort_ctrl.sv -----
// Sequencer for the counting sort engine: clearing pass, insert and drain.
`default_nettype none

module csort_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic                        req_op,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output csort_pkg::csort_cmd_type         cmd,
   input  wire csort_pkg::csort_status_type status
);

   csort_pkg::csort_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic is_drain;

   assign is_drain   = (req_op == csort_pkg::OP_DRAIN);
   assign req_tready = (state_ff == csort_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csort_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = csort_pkg::ST_IDLE;
         end
         csort_pkg::ST_IDLE: begin
            if (accept) begin
               if (!is_drain) state_in = csort_pkg::ST_LOOKUP;
               else if (!status.store_empty) state_in = csort_pkg::ST_SCAN;
            end
         end
         csort_pkg::ST_LOOKUP: begin
            state_in = csort_pkg::ST_IDLE;
         end
         csort_pkg::ST_SCAN: begin
            if (status.bin_nonzero) state_in = csort_pkg::ST_IDLE;
         end
         default: begin
            state_in = csort_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         csort_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         csort_pkg::ST_IDLE: begin
            cmd.accept   = accept;
            // an empty store answers a drain at once
            cmd.load_rsp = accept && is_drain && status.store_empty;
         end
         csort_pkg::ST_LOOKUP: begin
            cmd.finish_insert = 1'b1;
            cmd.load_rsp      = 1'b1;
         end
         csort_pkg::ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.load_rsp = status.bin_nonzero;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csort_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/csort_dp.sv -----
// Datapath: bin counter memory, drain cursor, sample total and result register.
`default_nettype none

module csort_dp #(
   parameter int unsigned BINS       = 4096,
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_op,
   input  wire logic [csort_pkg::VALUE_W-1:0]       req_sample,
   input  wire csort_pkg::csort_cmd_type            cmd,
   output csort_pkg::csort_status_type              status,
   output logic      [csort_pkg::VALUE_W-1:0]       rsp_value,
   output logic                                     rsp_got,
   output logic                                     rsp_rejected
);

   localparam int unsigned ADDR_W = $clog2(BINS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BINS - 1);
   localparam logic [16:0] BINS_W = 17'(BINS);

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [csort_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic range_ok_ff, range_ok_in;
   logic [csort_pkg::VALUE_W-1:0] value_ff, value_in;
   logic got_ff, got_in;
   logic rej_ff, rej_in;

   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic [COUNT_BITS-1:0] ram_rd_data;
   logic ram_wr_en;
   logic insert_reject;

   csort_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign insert_reject = !range_ok_ff
                       || (ram_rd_data == {COUNT_BITS{1'b1}})
                       || (total_ff == {csort_pkg::TOTAL_BITS{1'b1}});

   assign status.clear_last  = (clr_addr_ff == LAST_ADDR);
   assign status.bin_nonzero = (ram_rd_data != '0);
   assign status.store_empty = (total_ff == '0);

   // first read of an item goes to its bin or to the cursor; a scan walks upward
   always_comb begin
      if (cmd.accept) begin
         ram_rd_addr = (req_op == csort_pkg::OP_DRAIN) ? cursor_ff : ADDR_W'(req_sample);
      end else begin
         ram_rd_addr = rd_addr_ff + 1'b1;
      end
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      cursor_in   = cursor_ff;
      rd_addr_in  = rd_addr_ff;
      total_in    = total_ff;
      range_ok_in = range_ok_ff;
      value_in    = value_ff;
      got_in      = got_ff;
      rej_in      = rej_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_addr_ff;
      ram_wr_data = ram_rd_data;

      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
         clr_addr_in = clr_addr_ff + 1'b1;
      end

      if (cmd.accept) begin
         rd_addr_in  = ram_rd_addr;
         range_ok_in = ({5'd0, req_sample} < BINS_W);
         if (req_op == csort_pkg::OP_INSERT) cursor_in = '0;
      end

      if (cmd.finish_insert && !insert_reject) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = ram_rd_data + 1'b1;
         total_in    = total_ff + 1'b1;
      end

      if (cmd.scan) begin
         if (status.bin_nonzero) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data - 1'b1;
            total_in    = total_ff - 1'b1;
            cursor_in   = rd_addr_ff;
         end else begin
            rd_addr_in = ram_rd_addr;
         end
      end

      if (cmd.load_rsp) begin
         value_in = '0;
         got_in   = 1'b0;
         rej_in   = 1'b0;
         if (cmd.finish_insert) begin
            rej_in = insert_reject;
         end else if (cmd.scan) begin
            value_in = csort_pkg::VALUE_W'(rd_addr_ff);
            got_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         cursor_ff   <= '0;
         total_ff    <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         cursor_ff   <= cursor_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      range_ok_ff <= range_ok_in;
      value_ff    <= value_in;
      got_ff      <= got_in;
      rej_ff      <= rej_in;
   end

   assign rsp_value    = value_ff;
   assign rsp_got      = got_ff;
   assign rsp_rejected = rej_ff;

endmodule

`default_nettype wire

// ----- rtl/core/counting_sort_engine.sv -----
// Top level of the counting sort engine: controller, datapath and checks.
//
// Usage
//   req_* takes one item per transfer: tuser is the operation (insert or
//   drain), tdata[11:0] the sample to count on insert. rsp_* returns exactly
//   one result per item, in order: tdata[11:0] is the drained value, tuser[0]
//   says a value came back, tuser[1] says an insert was refused.
// Timing
//   An insert makes one bin counter read, then the write-back.
//   A drain reads from the drain cursor upward past any empty bins to the
//   next filled bin; the single read port of the counter memory tests one
//   bin per cycle. A drain of an empty store is answered without a read.
//   One item is in flight at a time.
// Reset
//   Synchronous, active high. After reset a clearing pass writes zero to
//   every counter, and req_tready stays low until it is done.
// Back-pressure
//   The result is held in an output register; while rsp_tready is low it
//   holds, and the next item is taken in the cycle that result leaves.
`default_nettype none

module counting_sort_engine #(
   parameter int unsigned BINS       = 4096,
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [11:0] sample_value, [15:12] zero
   input  wire logic        req_tuser,  // [0] op
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,  // [11:0] sorted_value, [15:12] zero
   output logic      [1:0]  rsp_tuser   // [0] got_value, [1] rejected
);

   csort_pkg::csort_cmd_type    cmd;
   csort_pkg::csort_status_type status;
   logic [csort_pkg::VALUE_W-1:0] rsp_value;
   logic rsp_got;
   logic rsp_rejected;

   // sequence clearing, inserts and drain scans
   csort_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // counters, cursor, total and the held result
   csort_dp #(
      .BINS       (BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_tuser),
      .req_sample   (req_tdata[11:0]),
      .cmd          (cmd),
      .status       (status),
      .rsp_value    (rsp_value),
      .rsp_got      (rsp_got),
      .rsp_rejected (rsp_rejected)
   );

   assign rsp_tdata = {4'd0, rsp_value};
   assign rsp_tuser = {rsp_rejected, rsp_got};

   // no request may enter while the clearing pass runs
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_tready
   ) else $error("request taken during clearing pass");

   // a scan hit must show up as a valid result carrying a value
   a_scan_hit_responds: assert property (
      @(posedge clock) disable iff (reset)
      (cmd.scan && status.bin_nonzero) |=> (rsp_tvalid && rsp_tuser[0])
   ) else $error("scan hit gave no value");

   // a result never both returns a value and refuses an insert
   a_got_xor_reject: assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1])
   ) else $error("result flags both set");

   // a drained value always names a real bin
   a_value_in_range: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> ({1'b0, rsp_tdata} < 17'(BINS))
   ) else $error("drained value beyond the last bin");

endmodule

`default_nettype wire

// ----- verif/tb_counting_sort_engine.sv -----
// Self-checking testbench for the counting sort engine, with a scoreboard that predicts each result.
`timescale 1ns / 100ps

module tb_counting_sort_engine;

   localparam int unsigned BIN_COUNT   = 4096;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned VALUE_W     = csort_pkg::VALUE_W;
   localparam int unsigned TOTAL_BITS  = csort_pkg::TOTAL_BITS;
   localparam int unsigned STALL_LIMIT = 50000;  // covers the clearing pass and a full-range scan
   localparam int unsigned PRINT_LIMIT = 40;

   localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TOTAL_BITS-1:0] STORE_MAX = {TOTAL_BITS{1'b1}};

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               got;
      logic               refused;
   } sort_result_type;

   // Scoreboard: keeps its own copy of the bin counters, the drain cursor and
   // the sample total, and queues the result each accepted request should give.
   class csort_scoreboard;
      logic [COUNT_W-1:0]    bin_count [BIN_COUNT];
      logic [VALUE_W-1:0]    cursor;
      logic [TOTAL_BITS-1:0] stored;
      sort_result_type       expected_q [$];
      int unsigned           fail_count;
      int unsigned           checked;
      int unsigned           inserts;
      int unsigned           refusals;
      int unsigned           drains;
      int unsigned           empty_drains;

      function new();
         foreach (bin_count[i]) bin_count[i] = '0;
         cursor       = '0;
         stored       = '0;
         fail_count   = 0;
         checked      = 0;
         inserts      = 0;
         refusals     = 0;
         drains       = 0;
         empty_drains = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Advance the sorted store by one request and queue its result.
      function void note_request(csort_pkg::csort_op_type op, logic [VALUE_W-1:0] sample);
         sort_result_type res;
         int unsigned     idx;
         res = '0;
         if (op == csort_pkg::OP_INSERT) begin
            inserts++;
            cursor = '0;  // any insert, refused or not, restarts the scan
            if (int'(sample) >= BIN_COUNT || bin_count[sample] == COUNT_MAX ||
                stored == STORE_MAX) begin
               res.refused = 1'b1;
               refusals++;
            end else begin
               bin_count[sample] = bin_count[sample] + 1'b1;
               stored            = stored + 1'b1;
            end
         end else begin
            drains++;
            if (stored == '0) begin
               empty_drains++;
            end else begin
               idx = cursor;
               while (idx < BIN_COUNT && bin_count[idx] == '0) idx++;
               if (idx < BIN_COUNT) begin
                  bin_count[idx] = bin_count[idx] - 1'b1;
                  stored         = stored - 1'b1;
                  cursor         = idx[VALUE_W-1:0];
                  res.value      = idx[VALUE_W-1:0];
                  res.got        = 1'b1;
               end
            end
         end
         expected_q.push_back(res);
      endfunction

      task report_mismatch(string field, int unsigned want, int unsigned seen);
         fail_count++;
         if (fail_count <= PRINT_LIMIT)
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, seen);
      endtask

      // Compare one result transfer with the oldest outstanding expectation.
      task check_result(logic [VALUE_W-1:0] value, logic got, logic refused);
         sort_result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", 0, 1);
         end else begin
            want = expected_q.pop_front();
            if (value !== want.value)     report_mismatch("sorted_value", want.value, value);
            if (got !== want.got)         report_mismatch("got_value", want.got, got);
            if (refused !== want.refused) report_mismatch("rejected", want.refused, refused);
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [11:0] sample_value, [15:12] zero
   logic        req_tuser  = 1'b0; // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [11:0] sorted_value, [15:12] zero
   logic [1:0]  rsp_tuser;         // [0] got_value, [1] rejected

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned quiet_cycles  = 0;

   csort_scoreboard sb;

   counting_sort_engine #(
      .BINS       (BIN_COUNT),
      .COUNT_BITS (COUNT_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: decide back-pressure once per cycle at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: note each request transfer first, then check any result transfer.
   // A result can never belong to a request accepted at the same edge, so the
   // order only matters for the queue, and this one keeps it right.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(csort_pkg::csort_op_type'(req_tuser), req_tdata[VALUE_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[VALUE_W-1:0], rsp_tuser[0], rsp_tuser[1]);
      end
   end

   // Watchdog: count cycles without any transfer; the clearing pass after reset
   // counts too, so the limit sits well above it and the longest scan.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Present one request, idling first at the current sender rate, and hold
   // it until the transfer. Valid stays high on return so the next call can
   // replace the item without dropping it.
   task automatic send_item(input csort_pkg::csort_op_type op,
                            input logic [VALUE_W-1:0] sample);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, sample};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic insert(input logic [VALUE_W-1:0] sample);
      send_item(csort_pkg::OP_INSERT, sample);
   endtask

   // The sample field is ignored on a drain, so fill it with junk.
   task automatic drain();
      send_item(csort_pkg::OP_DRAIN, VALUE_W'($urandom_range(4095)));
   endtask

   // Drop valid and hold off until every outstanding result has arrived.
   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Random traffic: mostly bursts of inserts followed by bursts of drains, so
   // the store fills, sorts and empties again; some bursts overrun into empty
   // drains, and a share of single random operations adds noise.
   task automatic run_random(input int unsigned count);
      int unsigned sent;
      int unsigned burst;
      int unsigned mode;
      int          base;
      int          pick;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(7) == 0) begin
            if ($urandom_range(1)) drain();
            else                   insert(VALUE_W'($urandom_range(4095)));
            sent++;
         end else begin
            burst = $urandom_range(1, 12);
            mode  = $urandom_range(3);
            base  = $urandom_range(4095);
            repeat (burst) begin
               case (mode)
                  0: pick = $urandom_range(4095);                  // spread: long scans
                  1: pick = base + $urandom_range(7);              // clustered duplicates
                  2: pick = $urandom_range(15);                    // bottom of the range
                  default: pick = 4095 - $urandom_range(15);       // top of the range
               endcase
               if (pick > 4095) pick = 4095;
               insert(VALUE_W'(pick));
               sent++;
            end
            repeat ($urandom_range(1, burst + 3)) begin
               drain();
               sent++;
            end
         end
      end
   endtask

   initial begin
      int unsigned left;
      sb = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed: drain of an empty store, the extremes and alternating bit
      // patterns, duplicates, a full ascending read-out, then an insert below
      // the cursor to show that it restarts the scan.
      drain();
      insert(12'd0);
      insert(12'hFFF);
      insert(12'h555);
      insert(12'hAAA);
      insert(12'd0);
      insert(12'hFFF);
      insert(12'd1);
      insert(12'd2048);
      repeat (9) drain();
      insert(12'd100);
      insert(12'd200);
      drain();
      insert(12'd50);
      drain();

      // Random: receiver-heavy idling, then sender-heavy, then none; pause the
      // sender between mixes until nothing is outstanding.
      hold_until_drained();
      send_idle_pct = 26;
      recv_idle_pct = 55;
      run_random(220);
      hold_until_drained();
      send_idle_pct = 55;
      recv_idle_pct = 26;
      run_random(220);
      hold_until_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(220);

      // Empty the store in order, then drain once more against the empty store.
      hold_until_drained();
      left = sb.stored;
      repeat (left) drain();
      drain();

      // Let the last results come out, then allow the tail to settle.
      hold_until_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d inserts (%0d refused) and %0d drains (%0d of an empty store).",
               sb.inserts, sb.refusals, sb.drains, sb.empty_drains);
      $display("Checked %0d results under three idle mixes, ending with the store emptied.",
               sb.checked);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
